### hdl/lbtc_pkg.sv
// Package for the block tag cache: shared constants, state codes and cell status type.
package lbtc_pkg;

  // Default number of slots in the recency chain.
  localparam int NumSlotsDefault = 32;

  // Default width of the stored block number.
  localparam int BlockNumberBitsDefault = 32;

  // Width of the block number fields on the ports.
  localparam int BlockFieldW = 32;

  // Width of the slot field on the result port.
  localparam int SlotFieldW = 5;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIX
  } ctrl_state_e;

  // Status that each cell reports to the controller.
  typedef struct packed {
    logic hit;   // token is here and this cell holds the requested block
    logic sel;   // token is here and the walk ends in this cell
  } cell_stat_t;

endpackage

### hdl/lbtc_cell.sv
// One recency position of the tag store, with its token and carry registers.
module lbtc_cell #(
  parameter int TAG_W = lbtc_pkg::BlockNumberBitsDefault,
  parameter int ID_W = $clog2(lbtc_pkg::NumSlotsDefault),
  parameter int CELL_INDEX = 0,
  parameter bit IS_LAST = 1'b0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                tok_i,
  input  logic                carry_valid_i,
  input  logic [TAG_W-1:0]    carry_tag_i,
  input  logic [ID_W-1:0]     carry_slot_i,
  input  logic [TAG_W-1:0]    req_tag_i,
  input  logic                fix_i,
  input  logic [ID_W-1:0]     fix_slot_i,
  output logic                tok_o,
  output logic                carry_valid_o,
  output logic [TAG_W-1:0]    carry_tag_o,
  output logic [ID_W-1:0]     carry_slot_o,
  output lbtc_pkg::cell_stat_t stat_o,
  output logic                valid_o,
  output logic [TAG_W-1:0]    tag_o,
  output logic [ID_W-1:0]     slot_o
);

  logic             tok_q, tok_d;
  logic             valid_q;
  logic [TAG_W-1:0] tag_q;
  logic [ID_W-1:0]  slot_q;
  logic             carry_valid_q;
  logic [TAG_W-1:0] carry_tag_q;
  logic [ID_W-1:0]  carry_slot_q;
  logic             match;
  logic             work;
  logic             pass;

  // Compare the held entry against the request while the token sits here.
  assign match = tok_q && valid_q && (tag_q == req_tag_i);
  assign work  = adv_i && tok_q;
  assign pass  = tok_q && !match && !IS_LAST;

  // The token moves one cell down on every advancing cycle.
  assign tok_d = adv_i ? tok_i : tok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= 1'b0;
      valid_q <= 1'b0;
      slot_q  <= ID_W'(CELL_INDEX);
    end else begin
      tok_q <= tok_d;
      if (work) begin
        valid_q <= carry_valid_i;
        slot_q  <= carry_slot_i;
      end else if (fix_i) begin
        slot_q <= fix_slot_i;
      end
    end
  end

  // Tag and the entry handed to the next cell.
  always_ff @(posedge clk_i) begin
    if (work) begin
      tag_q <= carry_tag_i;
    end
    if (work && pass) begin
      carry_valid_q <= valid_q;
      carry_tag_q   <= tag_q;
      carry_slot_q  <= slot_q;
    end
  end

  assign tok_o         = pass;
  assign carry_valid_o = carry_valid_q;
  assign carry_tag_o   = carry_tag_q;
  assign carry_slot_o  = carry_slot_q;
  assign stat_o.hit    = match;
  assign stat_o.sel    = tok_q && (match || IS_LAST);
  assign valid_o       = valid_q;
  assign tag_o         = tag_q;
  assign slot_o        = slot_q;

endmodule

### hdl/lru_block_tag_cache.sv
// Top level of the fully associative LRU tag store: controller, cell chain and result register.

// Each request walks down a chain of NUM_SLOTS cells ordered from most to least recent,
// one cell per cycle, pushing every entry it passes one place down. The walk stops at the
// cell that holds the block (hit) or at the last cell (miss, whose entry is evicted), and
// the fix state then writes the chosen slot number into the top cell.
// The result waits in an output register, so the next request is taken while it is pending.
// After reset all slots are empty and slot NUM_SLOTS-1 is replaced first.
module lru_block_tag_cache #(
  parameter int NUM_SLOTS = lbtc_pkg::NumSlotsDefault,
  parameter int BLOCK_NUMBER_BITS = lbtc_pkg::BlockNumberBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [lbtc_pkg::BlockFieldW-1:0] block_number_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             hit_o,
  output logic [lbtc_pkg::SlotFieldW-1:0]  slot_o,
  output logic                             evicted_valid_o,
  output logic [lbtc_pkg::BlockFieldW-1:0] evicted_block_o
);

  localparam int IdW   = $clog2(NUM_SLOTS);
  localparam int TagWideW =
      (BLOCK_NUMBER_BITS > lbtc_pkg::BlockFieldW) ? BLOCK_NUMBER_BITS : lbtc_pkg::BlockFieldW;
  localparam int IdWideW = (IdW > lbtc_pkg::SlotFieldW) ? IdW : lbtc_pkg::SlotFieldW;
  localparam int Last  = NUM_SLOTS - 1;

  lbtc_pkg::ctrl_state_e state_q, state_d;

  logic                         accept;
  logic                         step;
  logic                         adv;
  logic                         done;
  logic                         stall;
  logic                         res_hit;
  logic [IdW-1:0]               res_slot;
  logic                         res_ev_valid;
  logic [BLOCK_NUMBER_BITS-1:0] res_ev_tag;
  logic                         fix;

  logic [BLOCK_NUMBER_BITS-1:0] bn_q;
  logic [TagWideW-1:0]          bn_wide;
  logic [IdW-1:0]               fix_slot_q;

  logic                         out_valid_q;
  logic                         out_hit_q;
  logic [IdW-1:0]               out_slot_q;
  logic                         out_ev_valid_q;
  logic [BLOCK_NUMBER_BITS-1:0] out_ev_tag_q;
  logic [TagWideW-1:0]          ev_wide;
  logic [IdWideW-1:0]           slot_wide;

  // Chain wiring: index p is what flows into cell p.
  logic                         tok_in    [NUM_SLOTS];
  logic                         cv_in     [NUM_SLOTS];
  logic [BLOCK_NUMBER_BITS-1:0] ct_in     [NUM_SLOTS];
  logic [IdW-1:0]               cs_in     [NUM_SLOTS];
  logic                         tok_out   [NUM_SLOTS];
  logic                         cv_out    [NUM_SLOTS];
  logic [BLOCK_NUMBER_BITS-1:0] ct_out    [NUM_SLOTS];
  logic [IdW-1:0]               cs_out    [NUM_SLOTS];
  lbtc_pkg::cell_stat_t         stat      [NUM_SLOTS];
  logic                         cell_valid[NUM_SLOTS];
  logic [BLOCK_NUMBER_BITS-1:0] cell_tag  [NUM_SLOTS];
  logic [IdW-1:0]               cell_slot [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]         tok_vec;

  // Request handshake.
  assign in_ready_o = (state_q == lbtc_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Walk control: hold the chain when a finished walk finds the result register full.
  assign stall = done && out_valid_q && !out_ready_i;
  assign step  = (state_q == lbtc_pkg::ST_WALK) && !stall;
  assign adv   = step || accept;
  assign fix   = (state_q == lbtc_pkg::ST_FIX);

  // Requested block, cut or extended to the stored tag width.
  assign bn_wide = TagWideW'(block_number_i);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bn_q <= bn_wide[BLOCK_NUMBER_BITS-1:0];
    end
    if (step && done) begin
      fix_slot_q <= res_slot;
    end
  end

  // Cell chain; the top cell takes the requested block, its slot is written afterwards.
  for (genvar p = 0; p < NUM_SLOTS; p++) begin : g_cell
    if (p == 0) begin : g_top
      assign tok_in[p] = accept;
      assign cv_in[p]  = 1'b1;
      assign ct_in[p]  = bn_q;
      assign cs_in[p]  = '0;
    end else begin : g_mid
      assign tok_in[p] = tok_out[p-1];
      assign cv_in[p]  = cv_out[p-1];
      assign ct_in[p]  = ct_out[p-1];
      assign cs_in[p]  = cs_out[p-1];
    end

    lbtc_cell #(
      .TAG_W     (BLOCK_NUMBER_BITS),
      .ID_W      (IdW),
      .CELL_INDEX(p),
      .IS_LAST   (p == Last)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .adv_i        (adv),
      .tok_i        (tok_in[p]),
      .carry_valid_i(cv_in[p]),
      .carry_tag_i  (ct_in[p]),
      .carry_slot_i (cs_in[p]),
      .req_tag_i    (bn_q),
      .fix_i        (fix && (p == 0)),
      .fix_slot_i   (fix_slot_q),
      .tok_o        (tok_out[p]),
      .carry_valid_o(cv_out[p]),
      .carry_tag_o  (ct_out[p]),
      .carry_slot_o (cs_out[p]),
      .stat_o       (stat[p]),
      .valid_o      (cell_valid[p]),
      .tag_o        (cell_tag[p]),
      .slot_o       (cell_slot[p])
    );

    assign tok_vec[p] = stat[p].sel || tok_out[p];
  end

  // Gather the result from the one cell that holds the token.
  always_comb begin
    done     = 1'b0;
    res_hit  = 1'b0;
    res_slot = '0;
    for (int p = 0; p < NUM_SLOTS; p++) begin
      done    = done | stat[p].sel;
      res_hit = res_hit | stat[p].hit;
      if (stat[p].sel) begin
        res_slot = res_slot | cell_slot[p];
      end
    end
  end

  // A miss in the last cell evicts whatever that cell held.
  assign res_ev_valid = stat[Last].sel && !stat[Last].hit && cell_valid[Last];
  assign res_ev_tag   = res_ev_valid ? cell_tag[Last] : '0;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lbtc_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = lbtc_pkg::ST_WALK;
        end
      end
      lbtc_pkg::ST_WALK: begin
        if (step && done) begin
          state_d = lbtc_pkg::ST_FIX;
        end
      end
      lbtc_pkg::ST_FIX: begin
        state_d = lbtc_pkg::ST_IDLE;
      end
      default: begin
        state_d = lbtc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lbtc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (step && done) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (step && done) begin
      out_hit_q      <= res_hit;
      out_slot_q     <= res_slot;
      out_ev_valid_q <= res_ev_valid;
      out_ev_tag_q   <= res_ev_tag;
    end
  end

  assign ev_wide   = TagWideW'(out_ev_tag_q);
  assign slot_wide = IdWideW'(out_slot_q);

  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign slot_o          = slot_wide[lbtc_pkg::SlotFieldW-1:0];
  assign evicted_valid_o = out_ev_valid_q;
  assign evicted_block_o = ev_wide[lbtc_pkg::BlockFieldW-1:0];

  // The walk token never sits in more than one cell.
  a_token_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("walk token present in several cells");

  // While walking, exactly one cell holds the token.
  a_token_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lbtc_pkg::ST_WALK) |-> $onehot(tok_vec))
    else $error("walk token lost");

  // A pending result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_slot_q)))
    else $error("pending result overwritten");

  // After the slot write into the top cell, the state returns to idle in the next cycle.
  a_fix_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lbtc_pkg::ST_FIX) |=> (state_q == lbtc_pkg::ST_IDLE))
    else $error("slot write did not return to idle");

endmodule

### tb/sv/lru_block_tag_cache_checker.sv
// Checker for the LRU block tag cache: recency model, result scoreboard and failure count.
`timescale 1ns / 1ps

module lru_block_tag_cache_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [lbtc_pkg::BlockFieldW-1:0] block_number_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic                             hit_i,
  input  logic [lbtc_pkg::SlotFieldW-1:0]  slot_i,
  input  logic                             evicted_valid_i,
  input  logic [lbtc_pkg::BlockFieldW-1:0] evicted_block_i,
  output int                               fail_count_o,
  output int                               pending_o
);

  localparam int NumSlots = lbtc_pkg::NumSlotsDefault;

  // One lookup outcome as the block reports it.
  typedef struct packed {
    logic                             hit;
    logic [lbtc_pkg::SlotFieldW-1:0]  slot;
    logic                             evicted_valid;
    logic [lbtc_pkg::BlockFieldW-1:0] evicted_block;
  } lookup_t;

  // Model of the tag store. Position 0 of the recency list is the most recent slot.
  logic [lbtc_pkg::BlockFieldW-1:0] tag_q [NumSlots];
  logic                             filled_q [NumSlots];
  int                               recency_q [NumSlots];

  lookup_t lookups_due [$];
  int      mismatches;

  // Moves the slot at the given recency position to the front, shifting the rest down.
  function automatic void move_to_front(input int pos);
    int s;
    s = recency_q[pos];
    for (int p = pos; p > 0; p--) begin
      recency_q[p] = recency_q[p - 1];
    end
    recency_q[0] = s;
  endfunction

  // Looks up one block, updates the recency list and tags, and returns the outcome.
  function automatic lookup_t lookup_block(input logic [lbtc_pkg::BlockFieldW-1:0] bn);
    lookup_t r;
    int      victim;
    r = '0;
    for (int p = 0; p < NumSlots; p++) begin
      if (filled_q[recency_q[p]] && tag_q[recency_q[p]] == bn) begin
        r.hit  = 1'b1;
        r.slot = lbtc_pkg::SlotFieldW'(recency_q[p]);
        move_to_front(p);
        return r;
      end
    end
    // Miss: the least recent slot is refilled, and its old tag is reported if it held one.
    victim = recency_q[NumSlots - 1];
    r.slot = lbtc_pkg::SlotFieldW'(victim);
    if (filled_q[victim]) begin
      r.evicted_valid = 1'b1;
      r.evicted_block = tag_q[victim];
    end
    move_to_front(NumSlots - 1);
    tag_q[victim]    = bn;
    filled_q[victim] = 1'b1;
    return r;
  endfunction

  // Results are compared before the request of the same edge is modeled.
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NumSlots; i++) begin
        tag_q[i]     = '0;
        filled_q[i]  = 1'b0;
        recency_q[i] = i;
      end
      lookups_due.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (lookups_due.size() == 0) begin
          $error("result with no request outstanding: slot %0d", slot_i);
          mismatches++;
        end else begin
          want = lookups_due.pop_front();
          if (hit_i !== want.hit) begin
            $error("hit mismatch: expected %0d, got %0d", want.hit, hit_i);
            mismatches++;
          end
          if (slot_i !== want.slot) begin
            $error("slot mismatch: expected %0d, got %0d", want.slot, slot_i);
            mismatches++;
          end
          if (evicted_valid_i !== want.evicted_valid) begin
            $error("evicted_valid mismatch: expected %0d, got %0d",
                   want.evicted_valid, evicted_valid_i);
            mismatches++;
          end
          if (evicted_block_i !== want.evicted_block) begin
            $error("evicted_block mismatch: expected %h, got %h",
                   want.evicted_block, evicted_block_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        lookups_due.push_back(lookup_block(block_number_i));
      end
      fail_count_o <= mismatches;
      pending_o    <= lookups_due.size();
    end
  end

endmodule

### tb/sv/lru_block_tag_cache_tb.sv
// Testbench top for the LRU block tag cache: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps

module lru_block_tag_cache_tb;

  localparam int CycleLimit     = 1_000_000;
  localparam int RandomRequests = 1450;
  localparam int DrainCycles    = 40;
  localparam int PoolDepth      = 48;

  // Edge values first; all ones must miss while the cache holds only block zero.
  localparam logic [lbtc_pkg::BlockFieldW-1:0] Directed [14] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
    32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 32'h0000_0001,
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001,
    32'hFFFF_FFFE, 32'hAAAA_AAAA
  };

  logic                             clk            = 1'b0;
  logic                             rst_n          = 1'b0;
  logic                             in_valid       = 1'b0;
  logic [lbtc_pkg::BlockFieldW-1:0] block_number   = '0;
  logic                             out_ready      = 1'b0;
  logic                             in_ready;
  logic                             out_valid;
  logic                             hit;
  logic [lbtc_pkg::SlotFieldW-1:0]  slot;
  logic                             evicted_valid;
  logic [lbtc_pkg::BlockFieldW-1:0] evicted_block;
  int                               fail_count;
  int                               pending;
  int                               cycles         = 0;

  int rx_run;
  int rx_taken;
  logic rx_held;

  lru_block_tag_cache dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .block_number_i  (block_number),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .hit_o           (hit),
    .slot_o          (slot),
    .evicted_valid_o (evicted_valid),
    .evicted_block_o (evicted_block)
  );

  lru_block_tag_cache_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .block_number_i  (block_number),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .hit_i           (hit),
    .slot_i          (slot),
    .evicted_valid_i (evicted_valid),
    .evicted_block_i (evicted_block),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always #5 clk = ~clk;

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("lru_block_tag_cache test failed");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: random ready pattern, with one long hold-off after a few hundred results.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_run    <= 0;
      rx_taken  <= 0;
      rx_held   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        rx_taken <= rx_taken + 1;
      end
      if (!rx_held && rx_taken >= 300) begin
        rx_held   <= 1'b1;
        out_ready <= 1'b0;
        rx_run    <= 400;
      end else if (rx_run == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          out_ready <= 1'b0;
          rx_run    <= idle_gap();
        end else begin
          out_ready <= 1'b1;
          rx_run    <= ($urandom_range(0, 19) == 0) ? 150 : $urandom_range(1, 12);
        end
      end else begin
        rx_run <= rx_run - 1;
      end
    end
  end

  // Offers one request, waits for it to be taken, then idles for the given cycles.
  task automatic send_block(input logic [lbtc_pkg::BlockFieldW-1:0] bn, input int gap);
    in_valid     <= 1'b1;
    block_number <= bn;
    do @(posedge clk); while (!in_ready);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Request stream: directed edge cases, then a mix that reuses recent blocks.
  initial begin
    logic [lbtc_pkg::BlockFieldW-1:0] recent [$];
    logic [lbtc_pkg::BlockFieldW-1:0] bn;
    int                               pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (Directed[i]) begin
      recent.push_back(Directed[i]);
      send_block(Directed[i], idle_gap());
    end

    for (int n = 0; n < RandomRequests; n++) begin
      // Once in the middle, let the block drain completely before going on.
      if (n == 900) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      // Recent blocks give hits at every depth and refetches of evicted ones;
      // small numbers collide often; single-bit neighbors stress the tag compare.
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        bn = recent[$urandom_range(0, recent.size() - 1)];
      end else if (pick < 60) begin
        bn = $urandom_range(0, 47);
      end else if (pick < 70) begin
        bn = recent[$urandom_range(0, recent.size() - 1)] ^ (32'd1 << $urandom_range(0, 31));
      end else begin
        bn = $urandom();
      end
      recent.push_back(bn);
      if (recent.size() > PoolDepth) void'(recent.pop_front());
      send_block(bn, (n >= 200 && n < 400) ? 0 : idle_gap());
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0) begin
      $display("lru_block_tag_cache test passed");
    end else begin
      $display("lru_block_tag_cache test failed");
    end
    $finish;
  end

endmodule

### files.f
hdl/lbtc_pkg.sv
hdl/lbtc_cell.sv
hdl/lru_block_tag_cache.sv
tb/sv/lru_block_tag_cache_checker.sv
tb/sv/lru_block_tag_cache_tb.sv
